/* rtl/color_box_pixel_classifier_defines.svh */
// Assertion macros for the colour box pixel classifier checker.
// No dependencies; the including scope must provide clock and reset.
`ifndef COLOR_BOX_PIXEL_CLASSIFIER_DEFINES_SVH
`define COLOR_BOX_PIXEL_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CBPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define CBPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cbpc_pkg.sv */
// Package for the colour box pixel classifier: widths, class codes, beat types,
// box test and ratio field helper. No dependencies.
`timescale 1ns / 1ps

package cbpc_pkg;

   localparam int COUNT_BITS  = 20;
   localparam int RATIO_BITS  = 16;
   localparam int FIELD_W     = 16;
   localparam int WIDE_W      = (RATIO_BITS > FIELD_W) ? RATIO_BITS : FIELD_W;
   localparam int NUM_CLASSES = 9;
   localparam int NUM_RATIOS  = 8;
   localparam int IDX_W       = $clog2(NUM_RATIOS);
   localparam int STEP_W      = $clog2(RATIO_BITS);

   typedef logic [3:0] class_code_type;

   localparam class_code_type CLS_NONE       = 4'd0;
   localparam class_code_type CLS_ORANGE     = 4'd1;
   localparam class_code_type CLS_WHITE      = 4'd2;
   localparam class_code_type CLS_BLUE       = 4'd3;
   localparam class_code_type CLS_PURPLE     = 4'd4;
   localparam class_code_type CLS_BROWN      = 4'd5;
   localparam class_code_type CLS_RED        = 4'd6;
   localparam class_code_type CLS_LIGHT_BLUE = 4'd7;
   localparam class_code_type CLS_GREEN      = 4'd8;
   localparam class_code_type CLS_YELLOW     = 4'd9;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [RATIO_BITS-1:0] ratio_type;

   typedef struct packed {
      logic [7:0] blue_level;
      logic [7:0] green_level;
      logic [7:0] red_level;
      logic       frame_end;
   } req_payload_type;

   typedef struct packed {
      class_code_type     pixel_class;
      logic               ratios_valid;
      logic [FIELD_W-1:0] orange_ratio;
      logic [FIELD_W-1:0] white_ratio;
      logic [FIELD_W-1:0] blue_ratio;
      logic [FIELD_W-1:0] purple_ratio;
      logic [FIELD_W-1:0] brown_ratio;
      logic [FIELD_W-1:0] red_ratio;
      logic [FIELD_W-1:0] light_blue_ratio;
      logic [FIELD_W-1:0] green_ratio;
      logic [FIELD_W-1:0] max_warm_ratio;
   } rsp_payload_type;

   function automatic logic in_box(input logic [7:0] v, input logic [7:0] lo,
                                   input logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic class_code_type classify(input logic [7:0] b, input logic [7:0] g,
                                               input logic [7:0] r);
      class_code_type c;
      if (in_box(b, 8'd11, 8'd22) && in_box(g, 8'd85, 8'd105) && r >= 8'd240)
         c = CLS_ORANGE;
      else if (b >= 8'd253 && g >= 8'd253 && r >= 8'd253)
         c = CLS_WHITE;
      else if (in_box(b, 8'd150, 8'd190) && in_box(g, 8'd85, 8'd130) && r <= 8'd90)
         c = CLS_BLUE;
      else if (in_box(b, 8'd50, 8'd150) && g <= 8'd50 && r <= 8'd50)
         c = CLS_PURPLE;
      else if (in_box(b, 8'd95, 8'd135) && in_box(g, 8'd150, 8'd185)
               && in_box(r, 8'd180, 8'd210))
         c = CLS_BROWN;
      else if (b <= 8'd5 && g <= 8'd5 && r >= 8'd250)
         c = CLS_RED;
      else if (b <= 8'd50 && in_box(g, 8'd135, 8'd170) && r >= 8'd200)
         c = CLS_LIGHT_BLUE;
      else if (in_box(b, 8'd145, 8'd160) && in_box(g, 8'd170, 8'd200) && r <= 8'd40)
         c = CLS_GREEN;
      else if (b <= 8'd70 && in_box(g, 8'd180, 8'd220) && r >= 8'd230)
         c = CLS_YELLOW;
      else
         c = CLS_NONE;
      return c;
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input ratio_type v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[FIELD_W-1:0];
   endfunction

endpackage

/* rtl/color_box_pixel_classifier.sv */
// A pixel without frame end gives its registered beat on rsp in the cycle after acceptance;
// such pixels go through at one per cycle while rsp_ready is high.
// A frame-end pixel holds off input while one shared restoring divider works out the
// eight ratios one quotient bit per cycle, each in LOAD then STEP states, before FINISH.
// Reset (synchronous, active high) clears all class counts and empties the output.
`timescale 1ns / 1ps

module color_box_pixel_classifier (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cbpc_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cbpc_pkg::rsp_payload_type rsp_data
);
   import cbpc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOAD   = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   count_type             count_ff [NUM_CLASSES];
   ratio_type             ratio_ff [NUM_RATIOS];
   logic [COUNT_BITS:0]   rem_ff, rem_in;
   logic [COUNT_BITS:0]   den_ff, den_in;
   ratio_type             quot_ff, quot_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   class_code_type        cls_ff, cls_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   class_code_type        pix_class;
   count_type             cur_count;
   count_type             yellow_count;
   logic [COUNT_BITS+1:0] shifted;
   logic                  fits;
   logic                  div_done;
   ratio_type             warm_a;
   ratio_type             warm_max;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign pix_class  = classify(req_data.blue_level, req_data.green_level,
                                req_data.red_level);

   assign cur_count    = count_ff[idx_ff];
   assign yellow_count = count_ff[CLS_YELLOW - 1];
   assign shifted      = {rem_ff, 1'b0};
   assign fits         = shifted >= {1'b0, den_ff};
   assign div_done     = step_ff == STEP_W'(RATIO_BITS - 1);

   assign warm_a   = (ratio_ff[CLS_BROWN - 1] > ratio_ff[CLS_ORANGE - 1]) ?
                     ratio_ff[CLS_BROWN - 1] : ratio_ff[CLS_ORANGE - 1];
   assign warm_max = (ratio_ff[CLS_RED - 1] > warm_a) ? ratio_ff[CLS_RED - 1] : warm_a;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      cls_in       = cls_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.frame_end) begin
                  cls_in   = pix_class;
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  rsp_data_in             = '0;
                  rsp_data_in.pixel_class = pix_class;
                  rsp_valid_in            = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            rem_in   = {1'b0, cur_count};
            den_in   = {1'b0, cur_count} + {1'b0, yellow_count} + (COUNT_BITS+1)'(1);
            quot_in  = '0;
            step_in  = '0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            rem_in  = fits ? (COUNT_BITS+1)'(shifted - {1'b0, den_ff})
                           : shifted[COUNT_BITS:0];
            quot_in = {quot_ff[RATIO_BITS-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (div_done) begin
               if (idx_ff == IDX_W'(NUM_RATIOS - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_FINISH: begin
            rsp_data_in.pixel_class      = cls_ff;
            rsp_data_in.ratios_valid     = 1'b1;
            rsp_data_in.orange_ratio     = to_field(ratio_ff[CLS_ORANGE - 1]);
            rsp_data_in.white_ratio      = to_field(ratio_ff[CLS_WHITE - 1]);
            rsp_data_in.blue_ratio       = to_field(ratio_ff[CLS_BLUE - 1]);
            rsp_data_in.purple_ratio     = to_field(ratio_ff[CLS_PURPLE - 1]);
            rsp_data_in.brown_ratio      = to_field(ratio_ff[CLS_BROWN - 1]);
            rsp_data_in.red_ratio        = to_field(ratio_ff[CLS_RED - 1]);
            rsp_data_in.light_blue_ratio = to_field(ratio_ff[CLS_LIGHT_BLUE - 1]);
            rsp_data_in.green_ratio      = to_field(ratio_ff[CLS_GREEN - 1]);
            rsp_data_in.max_warm_ratio   = to_field(warm_max);
            rsp_valid_in                 = 1'b1;
            idx_in                       = '0;
            state_in                     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      cls_ff      <= cls_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_STEP && div_done) begin
         ratio_ff[idx_ff] <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (reset || state_ff == ST_FINISH) begin
            count_ff[i] <= '0;
         end else if (req_accept && pix_class == class_code_type'(i + 1)
                      && count_ff[i] != '1) begin
            count_ff[i] <= count_ff[i] + COUNT_BITS'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/cbpc_checker.sv */
// Port-level checker for the colour box pixel classifier, bound to the top level.
// Depends on cbpc_pkg and color_box_pixel_classifier_defines.svh.
`timescale 1ns / 1ps
`include "color_box_pixel_classifier_defines.svh"

module cbpc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input cbpc_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input cbpc_pkg::rsp_payload_type rsp_data
);
   import cbpc_pkg::*;

   `CBPC_ASSERT_NOW(a_no_take_when_blocked, req_ready, !rsp_valid || rsp_ready, "req taken while rsp beat blocked")
   `CBPC_ASSERT_NEXT(a_plain_pixel_beat, req_valid && req_ready && !req_data.frame_end, rsp_valid && !rsp_data.ratios_valid, "plain pixel gave no plain rsp beat")
   `CBPC_ASSERT_NEXT(a_frame_end_busy, req_valid && req_ready && req_data.frame_end, !req_ready && !rsp_valid, "frame end did not hold off input")
   `CBPC_ASSERT_NOW(a_plain_zero_ratios, rsp_valid && !rsp_data.ratios_valid, rsp_data.orange_ratio == '0 && rsp_data.max_warm_ratio == '0 && rsp_data.green_ratio == '0, "plain beat carries ratios")
   `CBPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat dropped or changed while stalled")

endmodule

bind color_box_pixel_classifier cbpc_checker u_cbpc_checker (.*);
